### sv/scsu_pkg.sv
// ----------------------------------------------------------------------------
// scsu_pkg
// Shared widths, pipeline depth and register codes for the sprite clip and
// scale setup core.
// ----------------------------------------------------------------------------
package scsu_pkg;

  localparam int FRACTION_BITS = 16;

  // field widths
  localparam int POS_W   = 16;
  localparam int SIZE_W  = 11;
  localparam int PIVOT_W = 17;
  localparam int SCALE_W = 24;
  localparam int SCR_W   = 13;
  localparam int DST_W   = 17;
  localparam int SRC_W   = 32;
  localparam int STEP_W  = 27;

  // internal widths
  localparam int P1_W   = SIZE_W + SCALE_W;
  localparam int SPAN_W = P1_W - FRACTION_BITS;
  localparam int P2_W   = SPAN_W + PIVOT_W;
  localparam int OFF_W  = P2_W - FRACTION_BITS;
  localparam int E_W    = OFF_W + 2;
  localparam int Q_W    = SIZE_W + FRACTION_BITS;

  // divider: a few quotient bits per stage
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = (Q_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DV_W       = DIV_STAGES * DIV_STEPS;

  localparam int NUM_STAGES = DIV_STAGES + 5;

  localparam logic [PIVOT_W-1:0] PIVOT_ONE = PIVOT_W'(1) << FRACTION_BITS;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SCR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH,
    REG_SCREEN_HEIGHT
  } cfg_reg_t;

  localparam logic [SCR_W-1:0] SCREEN_WIDTH_RESET  = SCR_W'(320);
  localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RESET = SCR_W'(240);

endpackage

### sv/scsu_axis.sv
// ----------------------------------------------------------------------------
// scsu_axis
// One axis of the sprite setup: scaled span, pivot offset, pipelined step
// division, edge clipping and source trimming.
// ----------------------------------------------------------------------------
module scsu_axis (
  input  logic                                   clk,
  input  scsu_pkg::stage_en_t                    adv,
  input  logic signed [scsu_pkg::POS_W-1:0]      pos,
  input  logic        [scsu_pkg::SIZE_W-1:0]     size,
  input  logic        [scsu_pkg::PIVOT_W-1:0]    pivot,
  input  logic        [scsu_pkg::SCALE_W-1:0]    scale,
  input  logic                                   scaled,
  input  logic        [scsu_pkg::SCR_W-1:0]      screen,
  output logic signed [scsu_pkg::DST_W-1:0]      dst_lo,
  output logic signed [scsu_pkg::DST_W-1:0]      dst_hi,
  output logic signed [scsu_pkg::SRC_W-1:0]      src_lo,
  output logic signed [scsu_pkg::SRC_W-1:0]      src_hi,
  output logic        [scsu_pkg::STEP_W-1:0]     step
);

  localparam int M_W = scsu_pkg::E_W + scsu_pkg::Q_W;

  typedef struct packed {
    logic signed [scsu_pkg::E_W-1:0]  a;
    logic signed [scsu_pkg::E_W-1:0]  b;
    logic [scsu_pkg::SIZE_W-1:0]      size;
    logic                             scaled;
    logic [scsu_pkg::SCR_W-1:0]       screen;
    logic [scsu_pkg::SPAN_W-1:0]      span;
    logic [scsu_pkg::SPAN_W-1:0]      rem;
    logic [scsu_pkg::DV_W-1:0]        dvd;
    logic [scsu_pkg::DV_W-1:0]        quo;
  } div_t;

  function automatic div_t div_stage(input div_t d);
    div_t                        n;
    logic [scsu_pkg::SPAN_W:0]   r;
    logic                        qb;
    n = d;
    for (int i = 0; i < scsu_pkg::DIV_STEPS; i++) begin
      r     = {n.rem, n.dvd[scsu_pkg::DV_W-1]};
      n.dvd = n.dvd << 1;
      qb    = (r >= {1'b0, n.span});
      if (qb) begin
        r = r - {1'b0, n.span};
      end
      n.rem = r[scsu_pkg::SPAN_W-1:0];
      n.quo = {n.quo[scsu_pkg::DV_W-2:0], qb};
    end
    return n;
  endfunction

  // stage 0: size times scale, pivot saturated
  logic signed [scsu_pkg::POS_W-1:0]   s0_pos;
  logic [scsu_pkg::SIZE_W-1:0]         s0_size;
  logic [scsu_pkg::PIVOT_W-1:0]        s0_pivot;
  logic                                s0_scaled;
  logic [scsu_pkg::SCR_W-1:0]          s0_screen;
  logic [scsu_pkg::P1_W-1:0]           s0_p1;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_pos    <= pos;
      s0_size   <= size;
      s0_pivot  <= (pivot > scsu_pkg::PIVOT_ONE) ? scsu_pkg::PIVOT_ONE : pivot;
      s0_scaled <= scaled;
      s0_screen <= screen;
      s0_p1     <= scsu_pkg::P1_W'(size) * scsu_pkg::P1_W'(scale);
    end
  end

  // stage 1: span and span times pivot
  logic [scsu_pkg::SPAN_W-1:0]         span_c;
  logic signed [scsu_pkg::POS_W-1:0]   s1_pos;
  logic [scsu_pkg::SIZE_W-1:0]         s1_size;
  logic                                s1_scaled;
  logic [scsu_pkg::SCR_W-1:0]          s1_screen;
  logic [scsu_pkg::SPAN_W-1:0]         s1_span;
  logic [scsu_pkg::P2_W-1:0]           s1_p2;

  assign span_c = s0_scaled ? s0_p1[scsu_pkg::P1_W-1:scsu_pkg::FRACTION_BITS]
                            : scsu_pkg::SPAN_W'(s0_size);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_pos    <= s0_pos;
      s1_size   <= s0_size;
      s1_scaled <= s0_scaled;
      s1_screen <= s0_screen;
      s1_span   <= span_c;
      s1_p2     <= scsu_pkg::P2_W'(span_c) * scsu_pkg::P2_W'(s0_pivot);
    end
  end

  // stage 2: unclipped edges, divider load
  logic signed [scsu_pkg::E_W-1:0] a_c;
  logic signed [scsu_pkg::E_W-1:0] b_c;
  div_t                            div_in;
  div_t                            div_q [scsu_pkg::DIV_STAGES+1];

  always_comb begin
    a_c = scsu_pkg::E_W'(s1_pos)
        - $signed({2'b00, s1_p2[scsu_pkg::P2_W-1:scsu_pkg::FRACTION_BITS]});
    b_c = a_c + $signed(scsu_pkg::E_W'(s1_span));
    div_in.a      = a_c;
    div_in.b      = b_c;
    div_in.size   = s1_size;
    div_in.scaled = s1_scaled;
    div_in.screen = s1_screen;
    div_in.span   = s1_span;
    div_in.rem    = '0;
    div_in.dvd    = scsu_pkg::DV_W'({s1_size, {scsu_pkg::FRACTION_BITS{1'b0}}});
    div_in.quo    = '0;
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      div_q[0] <= div_in;
    end
  end

  for (genvar k = 0; k < scsu_pkg::DIV_STAGES; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv[3+k]) begin
        div_q[k+1] <= div_stage(div_q[k]);
      end
    end
  end

  // clip products
  div_t                              d;
  logic [scsu_pkg::Q_W-1:0]          quo_c;
  logic [scsu_pkg::Q_W-1:0]          factor;
  logic [scsu_pkg::E_W-1:0]          neg_a;
  logic signed [scsu_pkg::E_W:0]     diff;
  logic [M_W-1:0]                    pa_full;
  logic [M_W-1:0]                    pb_full;

  always_comb begin
    d       = div_q[scsu_pkg::DIV_STAGES];
    quo_c   = (d.span == '0) ? '0 : d.quo[scsu_pkg::Q_W-1:0];
    factor  = d.scaled ? quo_c : scsu_pkg::Q_W'(1);
    neg_a   = -d.a;
    diff    = $signed({d.b[scsu_pkg::E_W-1], d.b})
            - $signed((scsu_pkg::E_W+1)'(d.screen));
    pa_full = M_W'(neg_a) * M_W'(factor);
    pb_full = M_W'(diff[scsu_pkg::E_W-1:0]) * M_W'(factor);
  end

  logic signed [scsu_pkg::E_W-1:0]   m_a;
  logic signed [scsu_pkg::E_W-1:0]   m_b;
  logic                              m_clip_l;
  logic                              m_clip_r;
  logic [scsu_pkg::SCR_W-1:0]        m_screen;
  logic [scsu_pkg::SRC_W-1:0]        m_pa;
  logic [scsu_pkg::SRC_W-1:0]        m_pb;
  logic [scsu_pkg::SRC_W-1:0]        m_base;
  logic [scsu_pkg::STEP_W-1:0]       m_step;

  always_ff @(posedge clk) begin
    if (adv[3+scsu_pkg::DIV_STAGES]) begin
      m_a      <= d.a;
      m_b      <= d.b;
      m_clip_l <= d.a < 0;
      m_clip_r <= diff > 0;
      m_screen <= d.screen;
      m_pa     <= pa_full[scsu_pkg::SRC_W-1:0];
      m_pb     <= pb_full[scsu_pkg::SRC_W-1:0];
      m_base   <= d.scaled ? scsu_pkg::SRC_W'({d.size, {scsu_pkg::FRACTION_BITS{1'b0}}})
                           : scsu_pkg::SRC_W'(d.size);
      m_step   <= d.scaled ? scsu_pkg::STEP_W'(quo_c) : '0;
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (adv[4+scsu_pkg::DIV_STAGES]) begin
      dst_lo <= m_clip_l ? '0 : m_a[scsu_pkg::DST_W-1:0];
      dst_hi <= m_clip_r ? $signed(scsu_pkg::DST_W'(m_screen)) : m_b[scsu_pkg::DST_W-1:0];
      src_lo <= m_clip_l ? $signed(m_pa) : '0;
      src_hi <= $signed(m_base - (m_clip_r ? m_pb : '0));
      step   <= m_step;
    end
  end

endmodule

### sv/sprite_clip_scale_setup_core.sv
// ----------------------------------------------------------------------------
// sprite_clip_scale_setup_core
// Per-sprite destination and source rectangle setup with screen clipping.
// ----------------------------------------------------------------------------
// Takes one sprite beat per clock unless stalled and returns its clipped
// destination and source rectangles after NUM_STAGES (14) stages; the depth
// is set by the step divider, which resolves three quotient bits per stage.
// A stalled output back-pressures only as far as the first empty stage, so the
// input keeps accepting while bubbles remain. Screen size registers are written
// through the cfg port and should only change while the pipeline is empty.
module sprite_clip_scale_setup_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [scsu_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [scsu_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [scsu_pkg::POS_W-1:0]     pos_x,
  input  logic signed [scsu_pkg::POS_W-1:0]     pos_y,
  input  logic        [scsu_pkg::SIZE_W-1:0]    pic_width,
  input  logic        [scsu_pkg::SIZE_W-1:0]    pic_height,
  input  logic        [scsu_pkg::PIVOT_W-1:0]   pivot_x,
  input  logic        [scsu_pkg::PIVOT_W-1:0]   pivot_y,
  input  logic        [scsu_pkg::SCALE_W-1:0]   scale_x,
  input  logic        [scsu_pkg::SCALE_W-1:0]   scale_y,
  input  logic                                  scaling_mode,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [scsu_pkg::DST_W-1:0]     dst_left,
  output logic signed [scsu_pkg::DST_W-1:0]     dst_top,
  output logic signed [scsu_pkg::DST_W-1:0]     dst_right,
  output logic signed [scsu_pkg::DST_W-1:0]     dst_bottom,
  output logic signed [scsu_pkg::SRC_W-1:0]     src_left,
  output logic signed [scsu_pkg::SRC_W-1:0]     src_top,
  output logic signed [scsu_pkg::SRC_W-1:0]     src_right,
  output logic signed [scsu_pkg::SRC_W-1:0]     src_bottom,
  output logic        [scsu_pkg::STEP_W-1:0]    step_x,
  output logic        [scsu_pkg::STEP_W-1:0]    step_y
);

  logic [scsu_pkg::SCR_W-1:0] screen_width;
  logic [scsu_pkg::SCR_W-1:0] screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= scsu_pkg::SCREEN_WIDTH_RESET;
      screen_height <= scsu_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (scsu_pkg::cfg_reg_t'(cfg_index))
        scsu_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        scsu_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits per stage, a stage moves when it is empty or its successor moves
  scsu_pkg::stage_en_t v;
  scsu_pkg::stage_en_t adv;

  always_comb begin
    adv[scsu_pkg::NUM_STAGES-1] = !v[scsu_pkg::NUM_STAGES-1] || out_ready;
    for (int k = scsu_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < scsu_pkg::NUM_STAGES; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[scsu_pkg::NUM_STAGES-1];

  scsu_axis u_axis_x (
    .clk    (clk),
    .adv    (adv),
    .pos    (pos_x),
    .size   (pic_width),
    .pivot  (pivot_x),
    .scale  (scale_x),
    .scaled (scaling_mode),
    .screen (screen_width),
    .dst_lo (dst_left),
    .dst_hi (dst_right),
    .src_lo (src_left),
    .src_hi (src_right),
    .step   (step_x)
  );

  scsu_axis u_axis_y (
    .clk    (clk),
    .adv    (adv),
    .pos    (pos_y),
    .size   (pic_height),
    .pivot  (pivot_y),
    .scale  (scale_y),
    .scaled (scaling_mode),
    .screen (screen_height),
    .dst_lo (dst_top),
    .dst_hi (dst_bottom),
    .src_lo (src_top),
    .src_hi (src_bottom),
    .step   (step_y)
  );

`ifndef SYNTH
  a_reset_empties: assert property (@(posedge clk) rst |=> v == '0)
    else $error("pipeline not empty after reset");
  a_ready_on_bubble: assert property (@(posedge clk) disable iff (rst)
    (v != '1) |-> in_ready)
    else $error("input stalled while a stage is empty");
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v[0])
    else $error("accepted beat did not enter the first stage");
  a_output_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(step_x) && $stable(src_left)))
    else $error("stalled result changed");
`endif

endmodule
